[rtl/odo_pkg.sv]
// Shared types, constants and helper functions of the wheel odometry pose estimator.
package odo_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MPT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIX_TRUST  = 2'd2;

    localparam logic [31:0] MPT_RESET        = 32'd366360;
    localparam logic [18:0] WHEEL_BASE_RESET = 19'd15008;
    localparam logic [16:0] FIX_TRUST_RESET  = 17'd6554;
    localparam logic [16:0] TRUST_FULL       = 17'd65536;

    localparam logic signed [31:0] POS_RESET = 32'sd6554;

    localparam logic [29:0] BA_PER_RAD  = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
    localparam int unsigned        CORDIC_STEPS = 28;

    localparam logic [29:0] ATAN_BA [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5
    };

    typedef enum logic [1:0] {
        KIND_HOLD,
        KIND_DRIVE,
        KIND_FIX
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [15:0] d_right;
        logic [15:0] d_left;
        logic        in_place_turn;
        logic [31:0] fix_x;
        logic [31:0] fix_y;
        logic [31:0] fix_heading;
    } odo_item_t;

    typedef struct packed {
        logic [31:0] metres_per_tick;
        logic [18:0] wheel_base;
        logic [16:0] fix_trust;
    } odo_cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic [6:0]  count;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [31:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cord_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] sin;
        logic signed [31:0] cos;
    } cord_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // encoder wrap rule: forward wrap adds 65535, backwards running gives 0
    function automatic logic [15:0] tick_delta(input logic [15:0] cur, input logic [15:0] prev);
        logic [15:0] r;
        if (cur >= prev)
            r = cur - prev;
        else if (cur < 16'd32767 && prev > 16'd32767)
            r = cur + (16'hFFFF - prev);
        else
            r = '0;
        return r;
    endfunction

endpackage

[rtl/diff_drive_pose_estimator.sv]
// Top level of the differential-drive wheel odometry pose estimator.
// Usage:
//   Input words (in_valid/in_ready) carry both raw wheel counts and, with
//   action set, an external fix. Each input word yields exactly one result
//   word (out_valid/out_ready) with pose_x, pose_y, pose_heading, fix_seen.
//   Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) write
//   metres_per_tick, wheel_base and fix_trust; cfg_ready is always high and
//   writes are meant for when the block is idle.
// Sequencing:
//   A word that leaves the pose unchanged goes straight to the result; a fix
//   word blends x, y and heading (heading only during an in-place turn). A
//   dead-reckoning word uses the serial divider (one quotient bit per cycle,
//   two divides, or three when the half turn reaches 2^20 binary-angle units)
//   and the 28-step CORDIC. One word is worked on at a time.
// Reset and stall:
//   Reset returns the pose to (6554, 6554, 0), clears fix_seen, the stored
//   counts and the queue, and loads the default configuration. A two-entry
//   queue takes new words while a result waits; when out_ready stays low the
//   result is held and input stalls once the queue fills.
module diff_drive_pose_estimator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [15:0]                    right_ticks,
    input  logic [15:0]                    left_ticks,
    input  logic                           odometry_enable,
    input  logic                           in_place_turn,
    input  logic signed [31:0]             fix_x,
    input  logic signed [31:0]             fix_y,
    input  logic signed [31:0]             fix_heading,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             pose_x,
    output logic signed [31:0]             pose_y,
    output logic signed [31:0]             pose_heading,
    output logic                           fix_seen,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [odo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    odo_pkg::odo_cfg_t  cfg_reg;
    odo_pkg::odo_item_t q_item;
    logic               q_valid;
    logic               q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.metres_per_tick <= odo_pkg::MPT_RESET;
            cfg_reg.wheel_base      <= odo_pkg::WHEEL_BASE_RESET;
            cfg_reg.fix_trust       <= odo_pkg::FIX_TRUST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                odo_pkg::CFG_MPT:        cfg_reg.metres_per_tick <= cfg_data;
                odo_pkg::CFG_WHEEL_BASE: cfg_reg.wheel_base      <= cfg_data[18:0];
                odo_pkg::CFG_FIX_TRUST:  cfg_reg.fix_trust       <= cfg_data[16:0];
                default:                 cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    odo_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .right_ticks     (right_ticks),
        .left_ticks      (left_ticks),
        .odometry_enable (odometry_enable),
        .in_place_turn   (in_place_turn),
        .fix_x           (fix_x),
        .fix_y           (fix_y),
        .fix_heading     (fix_heading),
        .q_item          (q_item),
        .q_valid         (q_valid),
        .q_ready         (q_ready)
    );

    odo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .fix_seen     (fix_seen)
    );

endmodule

[rtl/odo_front.sv]
// Front end: takes input words, forms tick deltas, classifies them and queues them.
module odo_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [15:0]          right_ticks,
    input  logic [15:0]          left_ticks,
    input  logic                 odometry_enable,
    input  logic                 in_place_turn,
    input  logic signed [31:0]   fix_x,
    input  logic signed [31:0]   fix_y,
    input  logic signed [31:0]   fix_heading,
    output odo_pkg::odo_item_t   q_item,
    output logic                 q_valid,
    input  logic                 q_ready
);

    odo_pkg::odo_item_t slot_reg [2];
    logic [15:0]        prev_right_reg;
    logic [15:0]        prev_left_reg;
    logic               synced_reg;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push;
    logic               pop;
    odo_pkg::odo_item_t new_item;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid & in_ready;
    assign pop      = q_valid & q_ready;

    always_comb
    begin
        new_item.d_right       = odo_pkg::tick_delta(right_ticks, prev_right_reg);
        new_item.d_left        = odo_pkg::tick_delta(left_ticks, prev_left_reg);
        new_item.in_place_turn = in_place_turn;
        new_item.fix_x         = fix_x;
        new_item.fix_y         = fix_y;
        new_item.fix_heading   = fix_heading;
        if (action)
            new_item.kind = odo_pkg::KIND_FIX;
        else if (!synced_reg && odometry_enable && !in_place_turn)
            new_item.kind = odo_pkg::KIND_DRIVE;
        else
            new_item.kind = odo_pkg::KIND_HOLD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_right_reg <= '0;
            prev_left_reg  <= '0;
            synced_reg     <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (push)
            begin
                prev_right_reg <= right_ticks;
                prev_left_reg  <= left_ticks;
                if (action)
                    synced_reg <= 1'b1;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= new_item;
    end

endmodule

[rtl/odo_div.sv]
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
module odo_div (
    input  logic              clk,
    input  logic              rst_n,
    input  odo_pkg::div_req_t req,
    output odo_pkg::div_rsp_t rsp
);

    logic [63:0] num_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    assign trial = {rem_reg, num_reg[63]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= fits ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

endmodule

[rtl/odo_cordic.sv]
// Iterative CORDIC sine/cosine in Q30, one micro-rotation per cycle.
module odo_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  odo_pkg::cord_req_t req,
    output odo_pkg::cord_rsp_t rsp
);

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         step_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [33:0] z_init;
    logic signed [33:0] z_fold;
    logic               neg_fold;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] atan_s;
    logic signed [33:0] xc;
    logic signed [33:0] yc;

    assign rsp.done = done_reg;
    assign rsp.sin  = sin_reg;
    assign rsp.cos  = cos_reg;

    always_comb
    begin
        z_init = {{2{req.angle[31]}}, req.angle};
        // fold into +-quarter turn, flip the result sign afterwards
        if (z_init > odo_pkg::QUARTER_TURN)
        begin
            z_fold   = z_init - odo_pkg::HALF_TURN;
            neg_fold = 1'b1;
        end
        else if (z_init < -odo_pkg::QUARTER_TURN)
        begin
            z_fold   = z_init + odo_pkg::HALF_TURN;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_init;
            neg_fold = 1'b0;
        end
        xs     = x_reg >>> step_reg;
        ys     = y_reg >>> step_reg;
        atan_s = {4'b0, odo_pkg::ATAN_BA[step_reg]};
        if (x_reg > odo_pkg::ONE_Q30)
            xc = odo_pkg::ONE_Q30;
        else if (x_reg < -odo_pkg::ONE_Q30)
            xc = -odo_pkg::ONE_Q30;
        else
            xc = x_reg;
        if (y_reg > odo_pkg::ONE_Q30)
            yc = odo_pkg::ONE_Q30;
        else if (y_reg < -odo_pkg::ONE_Q30)
            yc = -odo_pkg::ONE_Q30;
        else
            yc = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(odo_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= odo_pkg::CORDIC_START;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_s;
            end
        end
        if (fin_reg)
        begin
            sin_reg <= neg_reg ? 32'(-yc) : 32'(yc);
            cos_reg <= neg_reg ? 32'(-xc) : 32'(xc);
        end
    end

endmodule

[rtl/odo_back.sv]
// Back end: sequencer that dead-reckons or blends the pose and registers the result word.
module odo_back (
    input  logic                clk,
    input  logic                rst_n,
    input  odo_pkg::odo_cfg_t   cfg,
    input  odo_pkg::odo_item_t  q_item,
    input  logic                q_valid,
    output logic                q_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pose_x,
    output logic signed [31:0]  pose_y,
    output logic signed [31:0]  pose_heading,
    output logic                fix_seen
);

    typedef enum logic [5:0] {
        S_IDLE, S_BX_MUL, S_BX_UPD, S_BY_MUL, S_BY_UPD, S_BH_MUL, S_BH_UPD,
        S_MR, S_ML, S_DIFF, S_DIV1, S_QL, S_QH, S_RB, S_DIV2_GO, S_DIV2,
        S_CHORD, S_CHSEL, S_HR, S_SQ, S_F, S_CS_WAIT, S_SB, S_FDIV_GO, S_FDIV,
        S_T1, S_T2, S_T3, S_HCS, S_SX1, S_SX2, S_SX3, S_SY2, S_SY3, S_UPD, S_EMIT
    } state_t;

    state_t              state_reg;
    odo_pkg::odo_item_t  item_reg;
    logic signed [31:0]  est_x_reg;
    logic signed [31:0]  est_y_reg;
    logic [31:0]         est_h_reg;
    logic                synced_reg;
    logic                out_valid_reg;
    logic signed [31:0]  pose_x_reg;
    logic signed [31:0]  pose_y_reg;
    logic [31:0]         pose_h_reg;
    logic                fix_seen_reg;

    logic [63:0]         mul_p_reg;
    logic signed [50:0]  prod_reg;
    logic [47:0]         lr_reg;
    logic [47:0]         csum_reg;
    logic                neg_reg;
    logic [47:0]         q_reg;
    logic [18:0]         r_reg;
    logic [54:0]         acc_reg;
    logic [31:0]         t1_reg;
    logic [31:0]         theta_reg;
    logic [31:0]         h_reg;
    logic [30:0]         hm_reg;
    logic [30:0]         sp_reg;
    logic [30:0]         f_reg;
    logic [47:0]         t_reg;
    logic signed [31:0]  s_reg;
    logic signed [31:0]  c_reg;
    logic [32:0]         qs_reg;
    logic [32:0]         qc_reg;

    odo_pkg::div_req_t   div_req;
    odo_pkg::div_rsp_t   div_rsp;
    odo_pkg::cord_req_t  cord_req;
    odo_pkg::cord_rsp_t  cord_rsp;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_full;
    logic signed [32:0]  blend_a;
    logic signed [17:0]  trust_s;
    logic signed [50:0]  blend_full;
    logic [16:0]         trust;
    logic [18:0]         wb;
    logic [47:0]         ll;
    logic [47:0]         dmag;
    logic [48:0]         sum49;
    logic [47:0]         term1_sum;
    logic [31:0]         turn;
    logic [31:0]         theta;
    logic [31:0]         h_val;
    logic [31:0]         h_abs;
    logic [55:0]         mq_sum;
    logic [47:0]         mq30;
    logic [48:0]         rnd_sum;
    logic [20:0]         v683;
    logic [30:0]         f_small;
    logic [30:0]         f_big;
    logic [30:0]         s_abs;
    logic [30:0]         c_abs;
    logic signed [34:0]  step_val;
    logic signed [50:0]  step_sum;
    logic signed [35:0]  ux;
    logic signed [35:0]  uy;
    logic signed [35:0]  bx;
    logic signed [35:0]  by;

    odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    odo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cord_req),
        .rsp   (cord_rsp)
    );

    assign q_ready      = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign pose_x       = pose_x_reg;
    assign pose_y       = pose_y_reg;
    assign pose_heading = pose_h_reg;
    assign fix_seen     = fix_seen_reg;

    assign mul_full   = mul_a * mul_b;
    assign trust_s    = $signed({1'b0, trust});
    assign blend_full = blend_a * trust_s;

    always_comb
    begin
        trust = (cfg.fix_trust > odo_pkg::TRUST_FULL) ? odo_pkg::TRUST_FULL : cfg.fix_trust;
        wb    = (cfg.wheel_base == '0) ? 19'd1 : cfg.wheel_base;

        ll    = mul_p_reg[47:0];
        dmag  = (lr_reg < ll) ? (ll - lr_reg) : (lr_reg - ll);
        sum49 = {1'b0, lr_reg} + {1'b0, ll};

        // (q * k) >> 16 modulo 2^32 needs the product modulo 2^48 only
        term1_sum = acc_reg[47:0] + {mul_p_reg[23:0], 24'b0};

        turn  = t1_reg + div_rsp.quo[31:0];
        theta = neg_reg ? (32'd0 - turn) : turn;
        h_val = {theta_reg[31], theta_reg[31:1]};
        h_abs = h_val[31] ? (32'd0 - h_val) : h_val;

        // floor(a*b / 2^30) from two 24-bit slices of a
        mq_sum  = {1'b0, acc_reg} + {16'b0, mul_p_reg[63:24]};
        mq30    = mq_sum[53:6];
        rnd_sum = {1'b0, mq30} + 49'd32768;

        // hr*hr / (3 * 2^31): shift, then divide by three via 683/2048
        v683    = 21'(mul_p_reg[41:31]) * 21'd683;
        f_small = 31'd1073741824 - {21'b0, v683[20:11]};
        f_big   = (div_rsp.quo > 64'd1073741824) ? 31'd1073741824 : div_rsp.quo[30:0];

        s_abs = s_reg[31] ? 31'(-s_reg) : s_reg[30:0];
        c_abs = c_reg[31] ? 31'(-c_reg) : c_reg[30:0];

        ux = s_reg[31] ? ({{4{est_x_reg[31]}}, est_x_reg} + {3'b0, qs_reg})
                       : ({{4{est_x_reg[31]}}, est_x_reg} - {3'b0, qs_reg});
        uy = c_reg[31] ? ({{4{est_y_reg[31]}}, est_y_reg} - {3'b0, qc_reg})
                       : ({{4{est_y_reg[31]}}, est_y_reg} + {3'b0, qc_reg});

        step_sum = prod_reg + 51'sd32768;
        step_val = step_sum[50:16];
        bx = {{4{est_x_reg[31]}}, est_x_reg} - {step_val[34], step_val};
        by = {{4{est_y_reg[31]}}, est_y_reg} - {step_val[34], step_val};
    end

    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        blend_a  = '0;
        div_req  = '0;
        cord_req = '0;
        unique case (state_reg)
            S_BX_MUL:
                blend_a = {est_x_reg[31], est_x_reg}
                        - {item_reg.fix_x[31], item_reg.fix_x};
            S_BY_MUL:
                blend_a = {est_y_reg[31], est_y_reg}
                        - {item_reg.fix_y[31], item_reg.fix_y};
            S_BH_MUL:
            begin
                blend_a = $signed({1'b0, est_h_reg - item_reg.fix_heading});
                blend_a[32] = blend_a[31];
            end
            S_MR:
            begin
                mul_a = {16'b0, item_reg.d_right};
                mul_b = cfg.metres_per_tick;
            end
            S_ML:
            begin
                mul_a = {16'b0, item_reg.d_left};
                mul_b = cfg.metres_per_tick;
            end
            S_DIFF:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {dmag, 16'b0};
                div_req.divisor  = {13'b0, wb};
                div_req.count    = 7'd48;
            end
            S_QL:
            begin
                mul_a = {8'b0, q_reg[23:0]};
                mul_b = {2'b0, odo_pkg::BA_PER_RAD};
            end
            S_QH:
            begin
                mul_a = {8'b0, q_reg[47:24]};
                mul_b = {2'b0, odo_pkg::BA_PER_RAD};
            end
            S_RB:
            begin
                mul_a = {13'b0, r_reg};
                mul_b = {2'b0, odo_pkg::BA_PER_RAD};
            end
            S_DIV2_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_p_reg[48:16], 31'b0};
                div_req.divisor  = {13'b0, wb};
                div_req.count    = 7'd33;
            end
            S_CHSEL:
            begin
                if (hm_reg >= 31'd1048576)
                begin
                    cord_req.start = 1'b1;
                    cord_req.angle = {1'b0, hm_reg};
                end
            end
            S_HR:
            begin
                mul_a = {12'b0, hm_reg[19:0]};
                mul_b = {1'b0, odo_pkg::HALF_PI_Q30};
            end
            S_SQ:
            begin
                mul_a = {11'b0, mul_p_reg[50:30]};
                mul_b = {11'b0, mul_p_reg[50:30]};
            end
            S_SB:
            begin
                mul_a = {1'b0, sp_reg};
                mul_b = {2'b0, odo_pkg::BA_PER_RAD};
            end
            S_FDIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_p_reg[59:0], 4'b0};
                div_req.divisor  = {1'b0, hm_reg};
                div_req.count    = 7'd60;
            end
            S_T1:
            begin
                mul_a = {8'b0, csum_reg[47:24]};
                mul_b = {1'b0, f_reg};
            end
            S_T2:
            begin
                mul_a = {8'b0, csum_reg[23:0]};
                mul_b = {1'b0, f_reg};
            end
            S_T3:
            begin
                cord_req.start = 1'b1;
                cord_req.angle = est_h_reg + h_reg;
            end
            S_SX1:
            begin
                mul_a = {8'b0, t_reg[47:24]};
                mul_b = {1'b0, s_abs};
            end
            S_SX2:
            begin
                mul_a = {8'b0, t_reg[23:0]};
                mul_b = {1'b0, s_abs};
            end
            S_SX3:
            begin
                mul_a = {8'b0, t_reg[47:24]};
                mul_b = {1'b0, c_abs};
            end
            S_SY2:
            begin
                mul_a = {8'b0, t_reg[23:0]};
                mul_b = {1'b0, c_abs};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_full;
        prod_reg  <= blend_full;
        unique case (state_reg)
            S_IDLE:    item_reg <= q_item;
            S_ML:      lr_reg <= mul_p_reg[47:0];
            S_DIFF:
            begin
                neg_reg  <= (lr_reg < ll);
                csum_reg <= sum49[48:1];
            end
            S_DIV1:
            begin
                q_reg <= div_rsp.quo[47:0];
                r_reg <= div_rsp.rem[18:0];
            end
            S_QH:      acc_reg <= {1'b0, mul_p_reg[53:0]};
            S_RB:      t1_reg <= term1_sum[47:16];
            S_DIV2:    theta_reg <= theta;
            S_CHORD:
            begin
                h_reg  <= h_val;
                hm_reg <= h_abs[30:0];
            end
            S_F:       f_reg <= f_small;
            S_CS_WAIT: sp_reg <= cord_rsp.sin[31] ? 31'd0 : cord_rsp.sin[30:0];
            S_FDIV:    f_reg <= f_big;
            S_T2:      acc_reg <= {1'b0, mul_p_reg[53:0]};
            S_T3:      t_reg <= mq30;
            S_HCS:
            begin
                s_reg <= cord_rsp.sin;
                c_reg <= cord_rsp.cos;
            end
            S_SX2:     acc_reg <= {1'b0, mul_p_reg[53:0]};
            S_SX3:     qs_reg <= rnd_sum[48:16];
            S_SY2:     acc_reg <= {1'b0, mul_p_reg[53:0]};
            S_SY3:     qc_reg <= rnd_sum[48:16];
            default:   neg_reg <= neg_reg;
        endcase
    end

    // sequencer, pose state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            est_x_reg     <= odo_pkg::POS_RESET;
            est_y_reg     <= odo_pkg::POS_RESET;
            est_h_reg     <= '0;
            synced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_h_reg    <= '0;
            fix_seen_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        unique case (q_item.kind)
                            odo_pkg::KIND_FIX:
                                state_reg <= q_item.in_place_turn ? S_BH_MUL : S_BX_MUL;
                            odo_pkg::KIND_DRIVE:
                                state_reg <= S_MR;
                            default:
                                state_reg <= S_EMIT;
                        endcase
                    end
                end
                S_BX_MUL:  state_reg <= S_BX_UPD;
                S_BX_UPD:
                begin
                    est_x_reg <= odo_pkg::sat32(bx);
                    state_reg <= S_BY_MUL;
                end
                S_BY_MUL:  state_reg <= S_BY_UPD;
                S_BY_UPD:
                begin
                    est_y_reg <= odo_pkg::sat32(by);
                    state_reg <= S_BH_MUL;
                end
                S_BH_MUL:  state_reg <= S_BH_UPD;
                S_BH_UPD:
                begin
                    est_h_reg  <= est_h_reg - step_val[31:0];
                    synced_reg <= 1'b1;
                    state_reg  <= S_EMIT;
                end
                S_MR:      state_reg <= S_ML;
                S_ML:      state_reg <= S_DIFF;
                S_DIFF:    state_reg <= S_DIV1;
                S_DIV1:
                begin
                    if (div_rsp.done)
                        state_reg <= S_QL;
                end
                S_QL:      state_reg <= S_QH;
                S_QH:      state_reg <= S_RB;
                S_RB:      state_reg <= S_DIV2_GO;
                S_DIV2_GO: state_reg <= S_DIV2;
                S_DIV2:
                begin
                    if (div_rsp.done)
                        state_reg <= S_CHORD;
                end
                S_CHORD:   state_reg <= S_CHSEL;
                S_CHSEL:   state_reg <= (hm_reg < 31'd1048576) ? S_HR : S_CS_WAIT;
                S_HR:      state_reg <= S_SQ;
                S_SQ:      state_reg <= S_F;
                S_F:       state_reg <= S_T1;
                S_CS_WAIT:
                begin
                    if (cord_rsp.done)
                        state_reg <= S_SB;
                end
                S_SB:      state_reg <= S_FDIV_GO;
                S_FDIV_GO: state_reg <= S_FDIV;
                S_FDIV:
                begin
                    if (div_rsp.done)
                        state_reg <= S_T1;
                end
                S_T1:      state_reg <= S_T2;
                S_T2:      state_reg <= S_T3;
                S_T3:      state_reg <= S_HCS;
                S_HCS:
                begin
                    if (cord_rsp.done)
                        state_reg <= S_SX1;
                end
                S_SX1:     state_reg <= S_SX2;
                S_SX2:     state_reg <= S_SX3;
                S_SX3:     state_reg <= S_SY2;
                S_SY2:     state_reg <= S_SY3;
                S_SY3:     state_reg <= S_UPD;
                S_UPD:
                begin
                    est_x_reg <= odo_pkg::sat32(ux);
                    est_y_reg <= odo_pkg::sat32(uy);
                    est_h_reg <= est_h_reg + theta_reg;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        pose_x_reg    <= est_x_reg;
                        pose_y_reg    <= est_y_reg;
                        pose_h_reg    <= est_h_reg;
                        fix_seen_reg  <= synced_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[dv/diff_drive_pose_estimator_tb.sv]
// Self-checking testbench of the differential-drive wheel odometry pose estimator.
module diff_drive_pose_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned RAD_BA    = 64'd683565276;
    localparam longint unsigned QTR_PI    = 64'd1686629713;
    localparam longint          UNIT_Q30  = 64'sd1073741824;
    localparam longint          MAX_CYCLES = 64'd3000000;

    typedef struct {
        bit signed [31:0] x;
        bit signed [31:0] y;
        bit [31:0]        heading;
        bit               seen;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [15:0] right_ticks = '0;
    logic [15:0] left_ticks = '0;
    logic odometry_enable = 1'b0;
    logic in_place_turn = 1'b0;
    logic signed [31:0] fix_x = '0;
    logic signed [31:0] fix_y = '0;
    logic signed [31:0] fix_heading = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic fix_seen;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [odo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor state and register copy
    longint est_x, est_y;
    bit [31:0] est_head;
    bit [15:0] last_r, last_l;
    bit synced;
    bit [31:0] mpt;
    bit [18:0] base;
    bit [16:0] trust;

    pose_t pose_q[$];
    int errors = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    longint cycles = 0;
    bit [15:0] cur_r = '0, cur_l = '0;   // last counts sent

    diff_drive_pose_estimator u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle);

    function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
        longint unsigned p, q;
        p = (a >> 24) * b;
        q = (a & 64'hFFFFFF) * b;
        return (p + (q >> 24)) >> 6;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void cordic(input bit [31:0] ang, output longint s_o, output longint c_o);
        longint z, x, y, nx, a;
        bit neg;
        z = longint'(signed'(ang));
        x = odo_pkg::CORDIC_START;
        y = 0;
        neg = 1'b0;
        if (z > UNIT_Q30)
        begin
            z -= 2 * UNIT_Q30;
            neg = 1'b1;
        end
        else if (z < -UNIT_Q30)
        begin
            z += 2 * UNIT_Q30;
            neg = 1'b1;
        end
        for (int i = 0; i < odo_pkg::CORDIC_STEPS; i++)
        begin
            a = odo_pkg::ATAN_BA[i];
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= a;
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += a;
            end
            x = nx;
        end
        if (x > UNIT_Q30) x = UNIT_Q30;
        if (x < -UNIT_Q30) x = -UNIT_Q30;
        if (y > UNIT_Q30) y = UNIT_Q30;
        if (y < -UNIT_Q30) y = -UNIT_Q30;
        s_o = neg ? -y : y;
        c_o = neg ? -x : x;
    endfunction

    function automatic longint unsigned count_step(bit [15:0] cur, bit [15:0] prev);
        if (cur >= prev)
            return cur - prev;
        if (cur < 16'd32767 && prev > 16'd32767)
            return longint'(cur) + (65535 - longint'(prev));
        return 0;
    endfunction

    function automatic bit [31:0] turn_angle(longint unsigned d, longint unsigned w);
        longint unsigned q, r, t;
        q = d / w;
        r = d % w;
        t = ((q * RAD_BA) >> 16) + (r * RAD_BA) / (w << 16);
        return t[31:0];
    endfunction

    function automatic longint unsigned chord_gain(longint unsigned hm);
        longint unsigned hr, f;
        longint s, c;
        if (hm < (64'd1 << 20))
        begin
            hr = (hm * QTR_PI) >> 30;
            return longint'(UNIT_Q30) - (hr * hr) / 64'd6442450944;
        end
        cordic(hm[31:0], s, c);
        if (s < 0)
            s = 0;
        f = (longint'(s) * RAD_BA) / hm;
        return (f > UNIT_Q30) ? UNIT_Q30 : f;
    endfunction

    function automatic longint travel_q16(longint unsigned t, longint v);
        longint unsigned m;
        longint q;
        m = mul_frac(t, v < 0 ? -v : v);
        q = longint'((m + 32768) >> 16);
        return v < 0 ? -q : q;
    endfunction

    function automatic longint blend(longint delta, longint tr);
        return (delta * tr + 32768) >>> 16;
    endfunction

    function automatic void dead_reckon(bit [15:0] r, bit [15:0] l);
        longint unsigned w, lr, ll, hm, t;
        bit [31:0] theta;
        longint h, s, c;
        w = (base == 0) ? 1 : base;
        lr = count_step(r, last_r) * mpt;
        ll = count_step(l, last_l) * mpt;
        if (lr >= ll)
            theta = turn_angle(lr - ll, w);
        else
            theta = 32'd0 - turn_angle(ll - lr, w);
        h = longint'(signed'(theta)) >>> 1;
        hm = (h < 0) ? -h : h;
        t = mul_frac((lr + ll) >> 1, chord_gain(hm));
        cordic(est_head + h[31:0], s, c);
        est_x = clamp32(est_x - travel_q16(t, s));
        est_y = clamp32(est_y + travel_q16(t, c));
        est_head += theta;
    endfunction

    function automatic void predict_pose(bit act, bit [15:0] r, bit [15:0] l, bit en,
                                         bit tp, bit [31:0] fx, bit [31:0] fy, bit [31:0] fh);
        longint tr, dh, step;
        pose_t p;
        if (act)
        begin
            tr = (trust > odo_pkg::TRUST_FULL) ? 65536 : trust;
            dh = longint'(signed'(est_head - fh));
            if (!tp)
            begin
                est_x = clamp32(est_x - blend(est_x - longint'(signed'(fx)), tr));
                est_y = clamp32(est_y - blend(est_y - longint'(signed'(fy)), tr));
            end
            step = blend(dh, tr);
            est_head -= step[31:0];
            synced = 1'b1;
        end
        else if (!synced && en && !tp)
            dead_reckon(r, l);
        last_r = r;
        last_l = l;
        p.x = est_x[31:0];
        p.y = est_y[31:0];
        p.heading = est_head;
        p.seen = synced;
        pose_q.push_back(p);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_q.size() == 0)
                report_mismatch("result word with none expected");
            else
            begin
                e = pose_q.pop_front();
                if (pose_x !== e.x)
                    report_mismatch($sformatf("pose_x %0d exp %0d", pose_x, e.x));
                if (pose_y !== e.y)
                    report_mismatch($sformatf("pose_y %0d exp %0d", pose_y, e.y));
                if (pose_heading !== e.heading)
                    report_mismatch($sformatf("pose_heading %h exp %h", pose_heading, e.heading));
                if (fix_seen !== e.seen)
                    report_mismatch($sformatf("fix_seen %b exp %b", fix_seen, e.seen));
            end
        end
    end

    task automatic send_word(bit act, bit [15:0] r, bit [15:0] l, bit en, bit tp,
                             bit [31:0] fx, bit [31:0] fy, bit [31:0] fh);
        if ($urandom_range(99) < snd_idle)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        action = act;
        right_ticks = r;
        left_ticks = l;
        odometry_enable = en;
        in_place_turn = tp;
        fix_x = fx;
        fix_y = fy;
        fix_heading = fh;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_pose(act, r, l, en, tp, fx, fy, fh);
        cur_r = r;
        cur_l = l;
    endtask

    task automatic drive(bit [15:0] r, bit [15:0] l, bit en, bit tp);
        send_word(1'b0, r, l, en, tp, $urandom, $urandom, $urandom);
    endtask

    task automatic fix(bit tp, bit [31:0] fx, bit [31:0] fy, bit [31:0] fh);
        send_word(1'b1, $urandom, $urandom, $urandom_range(1), tp, fx, fy, fh);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pose_q.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic cfg_write(logic [odo_pkg::CFG_IDX_W-1:0] idx, bit [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            odo_pkg::CFG_MPT:        mpt = data;
            odo_pkg::CFG_WHEEL_BASE: base = data[18:0];
            odo_pkg::CFG_FIX_TRUST:  trust = data[16:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_idle(int snd, int rcv);
        snd_idle = snd;
        rcv_idle = rcv;
    endtask

    task automatic test_drive_directed();
        drive(16'd0, 16'd0, 1'b1, 1'b0);
        drive(16'd100, 16'd100, 1'b1, 1'b0);         // straight
        drive(16'd300, 16'd150, 1'b1, 1'b0);         // right arc
        drive(16'd350, 16'd600, 1'b1, 1'b0);         // left arc
        drive(16'd340, 16'd590, 1'b1, 1'b0);         // running backwards
        drive(16'd400, 16'd650, 1'b0, 1'b0);         // disabled
        drive(16'd500, 16'd700, 1'b1, 1'b1);         // turning in place
        drive(16'd40000, 16'd700, 1'b1, 1'b0);
        drive(16'd100, 16'd40000, 1'b1, 1'b0);       // forward wrap on right
        drive(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        drive(16'd0, 16'd0, 1'b1, 1'b0);
        drive(16'd32767, 16'd0, 1'b1, 1'b0);
        wait_idle();
        cfg_write(odo_pkg::CFG_WHEEL_BASE, 32'd1);           // huge turns
        drive(16'd65000, 16'd10, 1'b1, 1'b0);
        drive(16'd65100, 16'd3000, 1'b1, 1'b0);
        wait_idle();
        cfg_write(odo_pkg::CFG_WHEEL_BASE, 32'd0);           // zero base acts as one
        cfg_write(odo_pkg::CFG_MPT, 32'hFFFF_FFFF);
        drive(16'd65300, 16'd3200, 1'b1, 1'b0);
        drive(16'd10, 16'd20000, 1'b1, 1'b0);
        drive(16'd30000, 16'd30000, 1'b1, 1'b0);    // saturates position
        drive(16'd60000, 16'd60000, 1'b1, 1'b0);
        wait_idle();
        cfg_write(odo_pkg::CFG_MPT, 32'd1);
        cfg_write(odo_pkg::CFG_WHEEL_BASE, 32'h7FFFF);
        drive(16'd60500, 16'd60010, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic random_drive_burst(int n);
        bit [15:0] r, l;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: begin r = $urandom; l = $urandom; end
                1: begin r = cur_r - $urandom_range(0, 200); l = cur_l - $urandom_range(0, 200); end
                2: begin r = cur_r + $urandom_range(0, 30000); l = cur_l + $urandom_range(0, 30000); end
                default: begin
                    r = cur_r + $urandom_range(0, 400);
                    l = cur_l + $urandom_range(0, 400);
                end
            endcase
            drive(r, l, $urandom_range(99) < 85, $urandom_range(99) < 10);
        end
        wait_idle();
    endtask

    task automatic test_drive_random();
        cfg_write(odo_pkg::CFG_MPT, odo_pkg::MPT_RESET);
        cfg_write(odo_pkg::CFG_WHEEL_BASE, odo_pkg::WHEEL_BASE_RESET);
        set_idle(19, 45);
        random_drive_burst(90);
        cfg_write(odo_pkg::CFG_MPT, $urandom);
        cfg_write(odo_pkg::CFG_WHEEL_BASE, $urandom_range(1, 64));
        set_idle(45, 19);
        random_drive_burst(90);
        cfg_write(odo_pkg::CFG_MPT, $urandom_range(1, 32'h0100_0000));
        cfg_write(odo_pkg::CFG_WHEEL_BASE, $urandom_range(1, 262144));
        set_idle(0, 0);
        random_drive_burst(90);
    endtask

    task automatic test_fix_directed();
        set_idle(19, 45);
        fix(1'b0, 32'sd100000, -32'sd50000, 32'h4000_0000);    // first fix, default trust
        drive(16'd1000, 16'd20, 1'b1, 1'b0);                    // no reckoning once synced
        fix(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000); // heading only
        wait_idle();
        cfg_write(odo_pkg::CFG_FIX_TRUST, 32'd65536);
        fix(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        fix(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        wait_idle();
        cfg_write(odo_pkg::CFG_FIX_TRUST, 32'd0);
        fix(1'b0, $urandom, $urandom, $urandom);
        wait_idle();
        cfg_write(odo_pkg::CFG_FIX_TRUST, 32'h1FFFF);                   // above full
        fix(1'b0, 32'sd6554, 32'sd6554, 32'h0);
        fix(1'b1, $urandom, $urandom, $urandom);
        wait_idle();
    endtask

    task automatic random_fix_burst(int n);
        bit [31:0] fx, fy, fh;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                fx = $urandom;
                fy = $urandom;
                fh = $urandom;
            end
            else
            begin
                fx = est_x[31:0] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                fy = est_y[31:0] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                fh = est_head + $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            end
            if ($urandom_range(1))
                fix($urandom_range(99) < 20, fx, fy, fh);
            else
                drive($urandom, $urandom, $urandom_range(1), $urandom_range(1));
        end
        wait_idle();
    endtask

    task automatic test_fix_random();
        cfg_write(odo_pkg::CFG_FIX_TRUST, odo_pkg::FIX_TRUST_RESET);
        set_idle(19, 45);
        random_fix_burst(90);
        cfg_write(odo_pkg::CFG_FIX_TRUST, $urandom_range(0, 65536));
        set_idle(45, 19);
        random_fix_burst(90);
        cfg_write(odo_pkg::CFG_FIX_TRUST, $urandom_range(0, 32'h1FFFF));
        set_idle(0, 0);
        random_fix_burst(90);
    endtask

    initial
    begin
        est_x = odo_pkg::POS_RESET;
        est_y = odo_pkg::POS_RESET;
        est_head = '0;
        last_r = '0;
        last_l = '0;
        synced = 1'b0;
        mpt = odo_pkg::MPT_RESET;
        base = odo_pkg::WHEEL_BASE_RESET;
        trust = odo_pkg::FIX_TRUST_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_drive_directed();
        test_drive_random();
        test_fix_directed();
        test_fix_random();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
